@@ rtl/srng_pkg.sv @@
// Shared constants and the generator step for the shuffled random generator.
// No dependencies; imported by the slot divider and the top level.
`default_nettype none

package srng_pkg;

  localparam int unsigned DATA_W = 31;
  localparam logic [DATA_W-1:0] LCG_MOD  = 31'h7FFF_FFFF;
  localparam logic [14:0]       LCG_MULT = 15'd16807;
  localparam logic [DATA_W-1:0] SEED_DEF = 31'd1;

  // Control state of the draw sequencer
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_WARM  = 6'b000010,
    S_DIVGO = 6'b000100,
    S_DIVWT = 6'b001000,
    S_READ  = 6'b010000,
    S_WRITE = 6'b100000
  } srng_state_t;

  // One generator step: g * 16807 mod (2^31 - 1), folded instead of divided
  function automatic logic [DATA_W-1:0] lcg_next(input logic [DATA_W-1:0] g);
    logic [45:0]     prod;
    logic [DATA_W:0] fold;
    prod = 46'(g) * 46'(LCG_MULT);
    fold = {1'b0, prod[DATA_W-1:0]} + (DATA_W+1)'(prod[45:DATA_W]);
    if (fold >= {1'b0, LCG_MOD}) begin
      fold = fold - {1'b0, LCG_MOD};
    end
    return fold[DATA_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ rtl/srng_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the shuffle table.
`default_nettype none

module srng_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, holds when idle
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/srng_slot_div.sv @@
// Three-stage divider: slot = prev / (1 + (2^31 - 2) / TABLE_DEPTH).
// Uses srng_pkg; reciprocal multiply, back-multiply, one-step correction.
`default_nettype none

module srng_slot_div
  import srng_pkg::*;
#(
  parameter int TABLE_DEPTH = 32
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  input  wire logic [DATA_W-1:0]              prev,
  output logic                                done,
  output logic      [$clog2(TABLE_DEPTH)-1:0] slot
);

  localparam int    AW       = $clog2(TABLE_DEPTH);
  localparam longint SLOT_DIV = 64'd1 + (64'd2147483646 / TABLE_DEPTH);
  localparam int    SHIFT    = 40;
  localparam longint RECIP    = (64'd1 << SHIFT) / SLOT_DIV;
  localparam int    RW       = $clog2(RECIP + 1);
  localparam int    PROD_W   = DATA_W + RW;

  logic [2:0]        vld_r;
  logic [AW-1:0]     q0_r, q1_r;
  logic [DATA_W-1:0] prev0_r, prev1_r;
  logic [DATA_W-1:0] qd_r;
  logic [AW-1:0]     slot_r;
  logic [PROD_W-1:0] est;
  logic [DATA_W-1:0] rem;
  logic [AW:0]       q_inc;
  logic [AW:0]       q_fix;

  // Stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[1:0], start};
    end
  end

  // Stage 0: quotient estimate, low by at most one
  assign est = PROD_W'(prev) * PROD_W'(RECIP);

  always_ff @(posedge clk) begin
    if (start) begin
      q0_r    <= est[SHIFT +: AW];
      prev0_r <= prev;
    end
  end

  // Stage 1: multiply the estimate back
  always_ff @(posedge clk) begin
    if (vld_r[0]) begin
      qd_r    <= DATA_W'(DATA_W'(q0_r) * DATA_W'(SLOT_DIV));
      q1_r    <= q0_r;
      prev1_r <= prev0_r;
    end
  end

  // Stage 2: bump the estimate when the remainder reaches the divisor, clamp
  assign rem   = prev1_r - qd_r;
  assign q_inc = (AW+1)'(q1_r) + (AW+1)'(1);
  assign q_fix = (rem >= DATA_W'(SLOT_DIV)) ? q_inc : (AW+1)'(q1_r);

  always_ff @(posedge clk) begin
    if (vld_r[1]) begin
      if (q_fix >= (AW+1)'(TABLE_DEPTH)) begin
        slot_r <= AW'(TABLE_DEPTH - 1);
      end else begin
        slot_r <= q_fix[AW-1:0];
      end
    end
  end

  assign done = vld_r[2];
  assign slot = slot_r;

endmodule

`default_nettype wire

@@ rtl/shuffled_lcg_random_generator.sv @@
// Shuffled minimal-standard random generator, top level.
// Uses srng_pkg, srng_ram (shuffle table) and srng_slot_div (slot index).
//
// Usage:
//   Input channel (in_valid/in_ready, in_reseed): each beat requests one
//   draw. in_reseed = 1 restarts generator and table from the seed before
//   drawing. Result channel (out_valid/out_ready, out_random_value): one
//   beat per request, value in 1 .. 2^31 - 2, in request order.
//   cfg_wr_en/cfg_wr_data write the seed; write only while idle.
// Timing:
//   A draw runs from accept to the next accept through a table read,
//   the write back, then the three-stage slot divider that turns the new
//   output into the next table address. The result is registered at
//   the write back. A warm-up (first request after reset, or reseed) adds
//   TABLE_DEPTH + EXTRA_WARMUP generator steps, one per cycle, plus one
//   divider pass.
// Reset:
//   Seed returns to 1, the table is marked empty, so the next request
//   warms up. No clearing pass is needed.
// Stall:
//   A finished result waits in the output register; the next request is
//   still accepted and stalls only at its write-back until out_ready.
`default_nettype none

module shuffled_lcg_random_generator
  import srng_pkg::*;
#(
  parameter int TABLE_DEPTH  = 32,
  parameter int EXTRA_WARMUP = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              in_reseed,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic      [DATA_W-1:0] out_random_value,
  input  wire logic              cfg_wr_en,
  input  wire logic [DATA_W-1:0] cfg_wr_data
);

  localparam int AW   = $clog2(TABLE_DEPTH);
  localparam int CW   = $clog2(TABLE_DEPTH + EXTRA_WARMUP + 1);
  localparam int LAST = TABLE_DEPTH + EXTRA_WARMUP - 1;

  srng_state_t       state_r, state_nxt;
  logic [DATA_W-1:0] seed_r;
  logic [DATA_W-1:0] gen_r;
  logic [DATA_W-1:0] prev_r;
  logic              tbl_ready_r;
  logic              pend_r;
  logic [CW-1:0]     cnt_r;
  logic [AW-1:0]     slot_r;
  logic              out_valid_r;
  logic [DATA_W-1:0] out_value_r;

  logic              in_fire;
  logic              need_warm;
  logic              out_free;
  logic              wr_fire;
  logic              warm_wr;
  logic [DATA_W-1:0] gen_step;
  logic [DATA_W-1:0] seed_fix;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [DATA_W-1:0] ram_rdata;
  logic              div_start;
  logic              div_done;
  logic [AW-1:0]     div_slot;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign need_warm = in_reseed || !tbl_ready_r;
  assign out_free  = !out_valid_r || out_ready;
  assign wr_fire   = (state_r == S_WRITE) && out_free;
  assign warm_wr   = (state_r == S_WARM) && (cnt_r < CW'(TABLE_DEPTH));
  assign gen_step  = lcg_next(gen_r);
  assign div_start = (state_r == S_DIVGO);

  // Force a stuck seed to 1
  assign seed_fix = (seed_r == '0 || seed_r == LCG_MOD) ? SEED_DEF : seed_r;

  // Seed register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= SEED_DEF;
    end else if (cfg_wr_en) begin
      seed_r <= cfg_wr_data;
    end
  end

  // Sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_fire) state_nxt = need_warm ? S_WARM : S_READ;
      S_WARM:  if (cnt_r == '0) state_nxt = S_DIVGO;
      S_DIVGO: state_nxt = S_DIVWT;
      S_DIVWT: if (div_done) state_nxt = pend_r ? S_READ : S_IDLE;
      S_READ:  state_nxt = S_WRITE;
      S_WRITE: if (out_free) state_nxt = S_DIVGO;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tbl_ready_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_fire) begin
        pend_r <= 1'b1;
      end else if (wr_fire) begin
        pend_r <= 1'b0;
      end
      if (state_r == S_WARM && cnt_r == '0) begin
        tbl_ready_r <= 1'b1;
      end
    end
  end

  // Generator, warm-up counter and previous output
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_r  <= '0;
      prev_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (in_fire && need_warm) begin
        gen_r <= seed_fix;
        cnt_r <= CW'(LAST);
      end
      if (state_r == S_WARM) begin
        gen_r <= gen_step;
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == '0) begin
          prev_r <= gen_step;
        end
      end
      if (state_r == S_READ) begin
        gen_r <= gen_step;
      end
      if (wr_fire) begin
        prev_r <= ram_rdata;
      end
    end
  end

  // Latch the slot for the next draw
  always_ff @(posedge clk) begin
    if (state_r == S_DIVWT && div_done) begin
      slot_r <= div_slot;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (wr_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_fire) begin
      out_value_r <= ram_rdata;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_random_value = out_value_r;

  // Table write: warm-up fill or refill of the drawn slot
  assign ram_we    = warm_wr || wr_fire;
  assign ram_waddr = (state_r == S_WARM) ? cnt_r[AW-1:0] : slot_r;
  assign ram_wdata = (state_r == S_WARM) ? gen_step : gen_r;

  srng_ram #(
    .WIDTH (DATA_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (state_r == S_READ),
    .raddr (slot_r),
    .rdata (ram_rdata)
  );

  srng_slot_div #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_slot_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .prev  (prev_r),
    .done  (div_done),
    .slot  (div_slot)
  );

endmodule

`default_nettype wire

@@ tb/sv/srng_checker.sv @@
// Scoreboard for the shuffled random generator: watches the request, result and
// seed ports, predicts each draw and compares it with the returned beat.
// Depends on srng_pkg for the data width, modulus, multiplier and seed default.
module srng_checker
  import srng_pkg::*;
#(
  parameter int TABLE_DEPTH  = 32,
  parameter int EXTRA_WARMUP = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic              in_reseed,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [DATA_W-1:0] out_random_value,
  input  logic              cfg_wr_en,
  input  logic [DATA_W-1:0] cfg_wr_data,
  output int                draws_pending,
  output int                fail_count
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam logic [63:0] SLOT_DIV = 64'd1 + (64'(LCG_MOD) - 64'd1) / 64'(TABLE_DEPTH);

  // Predicted generator state
  logic [DATA_W-1:0] seed_reg;
  logic [DATA_W-1:0] gen_value;
  logic [DATA_W-1:0] last_draw;
  logic [DATA_W-1:0] shuffle_slots [TABLE_DEPTH];
  bit                slots_loaded;

  logic [DATA_W-1:0] expected_draws [$];
  logic [DATA_W-1:0] want;
  int                mismatches = 0;

  // One step of the multiplicative generator, plain modulo arithmetic
  function automatic logic [DATA_W-1:0] mcg_step(input logic [DATA_W-1:0] g);
    logic [63:0] prod;
    prod = 64'(g) * 64'(LCG_MULT);
    return DATA_W'(prod % 64'(LCG_MOD));
  endfunction

  // Advance the predicted state by one request and return the drawn value
  function automatic logic [DATA_W-1:0] draw_next(input logic reseed);
    logic [DATA_W-1:0] g;
    logic [63:0]       slot;
    int                n;
    if (reseed || !slots_loaded) begin
      // Stuck seeds (zero or the modulus) fall back to one
      g = seed_reg;
      if (g == '0 || g == LCG_MOD) begin
        g = DATA_W'(1);
      end
      for (n = TABLE_DEPTH + EXTRA_WARMUP - 1; n >= 0; n--) begin
        g = mcg_step(g);
        if (n < TABLE_DEPTH) begin
          shuffle_slots[AW'(n)] = g;
        end
      end
      gen_value    = g;
      last_draw    = shuffle_slots[0];
      slots_loaded = 1'b1;
    end
    gen_value = mcg_step(gen_value);
    slot = 64'(last_draw) / SLOT_DIV;
    if (slot >= 64'(TABLE_DEPTH)) begin
      slot = 64'(TABLE_DEPTH - 1);
    end
    last_draw                  = shuffle_slots[AW'(slot)];
    shuffle_slots[AW'(slot)]   = gen_value;
    return last_draw;
  endfunction

  // Track seed writes, predict on each request beat, check each result beat
  always @(posedge clk) begin
    if (!rst_n) begin
      seed_reg     = SEED_DEF;
      gen_value    = '0;
      last_draw    = '0;
      slots_loaded = 1'b0;
      expected_draws.delete();
    end else begin
      if (cfg_wr_en) begin
        seed_reg = cfg_wr_data;
      end
      if (in_valid && in_ready) begin
        expected_draws.push_back(draw_next(in_reseed));
      end
      if (out_valid && out_ready) begin
        if (expected_draws.size() == 0) begin
          mismatches++;
          $error("random_value: expected none, got %0d", out_random_value);
        end else begin
          want = expected_draws.pop_front();
          if (out_random_value !== want) begin
            mismatches++;
            $error("random_value: expected %0d, got %0d", want, out_random_value);
          end
        end
      end
    end
    draws_pending <= expected_draws.size();
    fail_count    <= mismatches;
  end

endmodule

@@ tb/sv/testbench.sv @@
// Top of the shuffled random generator bench: clock, reset, request and seed
// stimulus, result back-pressure, watchdog and verdict.
// Depends on srng_pkg, the generator RTL and srng_checker.
module testbench;
  import srng_pkg::*;

  localparam int TABLE_DEPTH    = 32;
  localparam int EXTRA_WARMUP   = 8;
  localparam int STALL_LIMIT    = 3000;
  localparam int RX_HOLD_CYCLES = 150;
  localparam int PHASE_ITEMS    = 150;

  logic              clk         = 1'b0;
  logic              rst_n       = 1'b0;
  logic              in_valid    = 1'b0;
  logic              in_reseed   = 1'b0;
  logic              out_ready   = 1'b0;
  logic              cfg_wr_en   = 1'b0;
  logic [DATA_W-1:0] cfg_wr_data = '0;
  logic              in_ready;
  logic              out_valid;
  logic [DATA_W-1:0] out_random_value;
  int                draws_pending;
  int                fail_count;
  bit                hold_request = 1'b0;

  always #1 clk = ~clk;

  shuffled_lcg_random_generator #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .EXTRA_WARMUP(EXTRA_WARMUP)
  ) uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_reseed       (in_reseed),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_random_value(out_random_value),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data)
  );

  srng_checker #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .EXTRA_WARMUP(EXTRA_WARMUP)
  ) draw_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_reseed       (in_reseed),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_random_value(out_random_value),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .draws_pending   (draws_pending),
    .fail_count      (fail_count)
  );

  // Offer one request beat and hold it until accepted
  task automatic request_draw(input logic reseed);
    in_valid  <= 1'b1;
    in_reseed <= reseed;
    do begin
      @(posedge clk);
    end while (!(in_valid && in_ready));
  endtask

  // Drop valid and wait until every predicted draw has come back
  task automatic await_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (draws_pending != 0) begin
      @(posedge clk);
    end
  endtask

  // Write the seed once the block is idle
  task automatic write_seed(input logic [DATA_W-1:0] seed);
    await_drain();
    repeat (12) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= seed;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Result side: random stalls, one quiet window, one long hold-off on request
  initial begin : result_sink
    int  cycle_no;
    bit  hold_done;
    cycle_no  = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      cycle_no++;
      if (hold_request && !hold_done) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
      end else if (cycle_no >= 2000 && cycle_no < 3000) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= 6);
      end
    end
  end

  // Stop the run if no beat moves on either channel for too long
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    int                phase;
    int                k;
    logic              reseed;
    logic [DATA_W-1:0] phase_seed;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // The first draw warms up from the reset seed, then an explicit reseed
    request_draw(1'b0);
    request_draw(1'b0);
    request_draw(1'b0);
    request_draw(1'b1);
    // Zero seed: no warm-up until reseed, then it falls back to one
    write_seed('0);
    request_draw(1'b0);
    request_draw(1'b1);
    request_draw(1'b0);
    // Modulus as seed also falls back to one
    write_seed(LCG_MOD);
    request_draw(1'b1);
    request_draw(1'b0);
    // Largest valid seed
    write_seed(LCG_MOD - DATA_W'(1));
    request_draw(1'b1);
    request_draw(1'b0);
    request_draw(1'b0);
    // Alternating bit patterns
    write_seed(31'h2AAA_AAAA);
    request_draw(1'b1);
    request_draw(1'b0);
    write_seed(31'h5555_5555);
    request_draw(1'b1);
    request_draw(1'b1);
    request_draw(1'b0);

    // Random phases, each with its own seed
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          phase_seed = DATA_W'($urandom);
        end
        1: begin
          phase_seed = DATA_W'($urandom_range(1, 1000));
        end
        2: begin
          phase_seed = DATA_W'($urandom) | 31'h4000_0000;
        end
        default: begin
          phase_seed = DATA_W'($urandom);
        end
      endcase
      write_seed(phase_seed);
      for (k = 0; k < PHASE_ITEMS; k++) begin
        // Pause the sender until the block has drained
        if (phase == 1 && k == 75) begin
          await_drain();
        end
        // Let the receiver hold off while requests keep coming
        if (phase == 2 && k == 10) begin
          hold_request = 1'b1;
        end
        // Idle now and then, except over one long stretch
        if (!(phase == 3 && k >= 20 && k < 120) && $urandom_range(99) < 6) begin
          in_valid  <= 1'b0;
          in_reseed <= 1'($urandom_range(1));
          repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        reseed = (k == 0) ? 1'b1 : ($urandom_range(99) < 4);
        request_draw(reseed);
      end
    end

    await_drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
